FILE: hdl/bfse_pkg.sv
// ----------------------------------------------------------------------------
// bfse_pkg
// Types, codes and the fixed preamble for the bit-file section extractor.
// ----------------------------------------------------------------------------
package bfse_pkg;

  localparam int unsigned PREAMBLE_LEN = 13;

  localparam logic [7:0] NAME_LO   = 8'h61;  // 'a'
  localparam logic [7:0] NAME_HI   = 8'h65;  // 'e'
  localparam logic [7:0] NAME_E    = 8'h65;
  localparam logic [6:0] WANTED_RESET = 7'h65;
  localparam logic [31:0] MAX_SHORT_LEN = 32'd255;

  typedef enum logic [2:0] {
    PH_PREAMBLE = 3'd0,
    PH_NAME     = 3'd1,
    PH_LEN      = 3'd2,
    PH_SKIP     = 3'd3,
    PH_PAYLOAD  = 3'd4,
    PH_ENDED    = 3'd5
  } phase_t;

  typedef logic [2:0] status_t;
  localparam status_t ST_PARSING      = 3'd0;
  localparam status_t ST_BAD_PREAMBLE = 3'd1;
  localparam status_t ST_BAD_NAME     = 3'd2;
  localparam status_t ST_BAD_LENGTH   = 3'd3;
  localparam status_t ST_NOT_FOUND    = 3'd4;
  localparam status_t ST_COMPLETE     = 3'd5;

  // configuration register indexes
  localparam logic REG_WANTED = 1'b0;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  pre_idx;
    logic [7:0]  kind;
    logic [31:0] accum;
    logic [2:0]  len_left;
    logic [31:0] to_go;
    logic        found;
    status_t     end_status;
  } parse_state_t;

  localparam parse_state_t RESTART_STATE = '{
    phase:      PH_PREAMBLE,
    pre_idx:    4'd0,
    kind:       8'd0,
    accum:      32'd0,
    len_left:   3'd0,
    to_go:      32'd0,
    found:      1'b0,
    end_status: ST_PARSING
  };

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        payload_last;
    logic [31:0] section_size;
    status_t     status;
  } result_t;

  function automatic logic [7:0] preamble_byte(input logic [3:0] idx);
    logic [7:0] val;
    case (idx)
      4'd0:    val = 8'h00;
      4'd1:    val = 8'h09;
      4'd2:    val = 8'h0f;
      4'd3:    val = 8'hf0;
      4'd4:    val = 8'h0f;
      4'd5:    val = 8'hf0;
      4'd6:    val = 8'h0f;
      4'd7:    val = 8'hf0;
      4'd8:    val = 8'h0f;
      4'd9:    val = 8'hf0;
      4'd10:   val = 8'h00;
      4'd11:   val = 8'h00;
      4'd12:   val = 8'h01;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

FILE: hdl/bit_file_section_extractor_unit.sv
// ----------------------------------------------------------------------------
// bit_file_section_extractor_unit
// Walks a bit-file image byte by byte and passes out one section's content.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------
//  in_       | in_valid / in_stall  | data_byte, first_byte, last_byte
//  out_      | out_valid / out_stall| payload_byte/valid/last, section_size,
//            |                      | status
//  cfg_      | APB write/read       | wanted_section at byte address 0
//
// One item per cycle sustained while out_stall is low; an item passes the input
// register, then the parser feeding the result register. Sync active-low reset
// returns the parse to the preamble check and wanted_section to 'e'. A stall on
// the result side holds the result register; in_stall follows out_stall in the
// same cycle while both registers hold an item, and stays low while either is
// empty. Parse state advances only when an item moves to the result.
module bit_file_section_extractor_unit import bfse_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_payload_byte,
  output logic        out_payload_valid,
  output logic        out_payload_last,
  output logic [31:0] out_section_size,
  output logic [2:0]  out_status,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic       wanted_we;
  logic [6:0] wanted_section_r;

  logic       in_vld_r;
  logic [7:0] in_data_r;
  logic       in_first_r;
  logic       in_last_r;

  logic       out_vld_r;
  result_t    out_res_r;
  result_t    step_res;

  logic       out_load;
  logic       step_go;
  logic       in_take;

  // config register
  assign cfg_pready = 1'b1;
  assign wanted_we  = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_WANTED);
  assign cfg_prdata = (cfg_paddr[2] == REG_WANTED) ? {25'd0, wanted_section_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_section_r <= WANTED_RESET;
    end else if (wanted_we) begin
      wanted_section_r <= cfg_pwdata[6:0];
    end
  end

  // two-stage flow control
  assign out_load = !out_vld_r || !out_stall;
  assign step_go  = in_vld_r && out_load;
  assign in_stall = in_vld_r && !out_load;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (step_go) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r  <= in_data_byte;
      in_first_r <= in_first_byte;
      in_last_r  <= in_last_byte;
    end
  end

  bfse_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (step_go),
    .data_byte      (in_data_r),
    .first_byte     (in_first_r),
    .last_byte      (in_last_r),
    .wanted_section (wanted_section_r),
    .result         (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= step_go;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_payload_byte  = out_res_r.payload_byte;
  assign out_payload_valid = out_res_r.payload_valid;
  assign out_payload_last  = out_res_r.payload_last;
  assign out_section_size  = out_res_r.section_size;
  assign out_status        = out_res_r.status;

endmodule

FILE: hdl/bfse_parser.sv
// ----------------------------------------------------------------------------
// bfse_parser
// Parse state machine: one image byte per enabled cycle, result is combinational.
// ----------------------------------------------------------------------------
module bfse_parser import bfse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] data_byte,
  input  logic       first_byte,
  input  logic       last_byte,
  input  logic [6:0] wanted_section,
  output result_t    result
);

  parse_state_t st_r;
  parse_state_t st_nxt;
  parse_state_t base;
  logic [31:0]  accum_shift;
  logic [2:0]   left_dec;
  logic [31:0]  to_go_dec;
  logic [3:0]   idx_inc;

  // first_byte restarts the parse on this very byte
  assign base        = first_byte ? RESTART_STATE : st_r;
  assign accum_shift = {base.accum[23:0], data_byte};
  assign left_dec    = base.len_left - 3'd1;
  assign to_go_dec   = base.to_go - 32'd1;
  assign idx_inc     = base.pre_idx + 4'd1;

  // next state
  always_comb begin
    st_nxt = base;
    case (base.phase)
      PH_PREAMBLE: begin
        if ((base.pre_idx >= 4'(PREAMBLE_LEN)) || (data_byte != preamble_byte(base.pre_idx)))
        begin
          st_nxt.phase      = PH_ENDED;
          st_nxt.end_status = ST_BAD_PREAMBLE;
        end else begin
          st_nxt.pre_idx = idx_inc;
          if (idx_inc == 4'(PREAMBLE_LEN)) begin
            st_nxt.phase = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        if ((data_byte < NAME_LO) || (data_byte > NAME_HI)) begin
          st_nxt.phase      = PH_ENDED;
          st_nxt.end_status = ST_BAD_NAME;
        end else begin
          st_nxt.kind     = data_byte;
          st_nxt.accum    = 32'd0;
          st_nxt.len_left = (data_byte == NAME_E) ? 3'd4 : 3'd2;
          st_nxt.phase    = PH_LEN;
        end
      end
      PH_LEN: begin
        st_nxt.accum    = accum_shift;
        st_nxt.len_left = left_dec;
        if (left_dec == 3'd0) begin
          if ((base.kind != NAME_E) && (accum_shift > MAX_SHORT_LEN)) begin
            st_nxt.phase      = PH_ENDED;
            st_nxt.end_status = ST_BAD_LENGTH;
          end else if (base.kind == {1'b0, wanted_section}) begin
            st_nxt.found = 1'b1;
            st_nxt.to_go = accum_shift;
            if (accum_shift == 32'd0) begin
              st_nxt.phase      = PH_ENDED;
              st_nxt.end_status = ST_COMPLETE;
            end else begin
              st_nxt.phase = PH_PAYLOAD;
            end
          end else begin
            st_nxt.to_go = accum_shift;
            st_nxt.phase = (accum_shift == 32'd0) ? PH_NAME : PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        st_nxt.to_go = to_go_dec;
        if (to_go_dec == 32'd0) begin
          st_nxt.phase = PH_NAME;
        end
      end
      PH_PAYLOAD: begin
        st_nxt.to_go = to_go_dec;
        if (to_go_dec == 32'd0) begin
          st_nxt.phase      = PH_ENDED;
          st_nxt.end_status = ST_COMPLETE;
        end
      end
      default: begin
      end
    endcase

    // end of image closes any parse still open
    if (last_byte && (st_nxt.phase != PH_ENDED)) begin
      if (st_nxt.phase == PH_PREAMBLE) begin
        st_nxt.end_status = ST_BAD_PREAMBLE;
      end else if (st_nxt.found) begin
        st_nxt.end_status = ST_COMPLETE;
      end else begin
        st_nxt.end_status = ST_NOT_FOUND;
      end
      st_nxt.phase = PH_ENDED;
    end
  end

  // outputs
  always_comb begin
    result.payload_valid = (base.phase == PH_PAYLOAD);
    result.payload_byte  = result.payload_valid ? data_byte : 8'd0;
    // to_go is never zero in the payload phase
    result.payload_last  = result.payload_valid && ((base.to_go == 32'd1) || last_byte);
    result.section_size  = st_nxt.found ? st_nxt.accum : 32'd0;
    result.status        = st_nxt.end_status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= RESTART_STATE;
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

endmodule

FILE: hdl/bfse_checker.sv
// ----------------------------------------------------------------------------
// bfse_checker
// Port-level checks for the section extractor, bound to the top level.
// ----------------------------------------------------------------------------
module bfse_checker import bfse_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_payload_byte,
  input logic        out_payload_valid,
  input logic        out_payload_last,
  input logic [31:0] out_section_size,
  input logic [2:0]  out_status
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_byte) && $stable(out_status))
    else $error("result changed while stalled");

  a_last_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_last |-> out_payload_valid)
    else $error("payload_last without payload byte");

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload_valid |-> out_payload_byte == 8'd0)
    else $error("payload byte not zero when not valid");

  // content bytes only flow while parsing or on completion
  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_valid |->
      (out_status == ST_PARSING) || (out_status == ST_COMPLETE))
    else $error("payload byte with error status");

  // a found section never coexists with an error code
  a_size_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_section_size != 32'd0) |->
      (out_status == ST_PARSING) || (out_status == ST_COMPLETE))
    else $error("section size with error status");

endmodule

bind bit_file_section_extractor_unit bfse_checker u_bfse_checker (.*);
